// ===== src/pkwin_pkg.sv =====
`timescale 1ns / 1ps

package pkwin_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_NUM_SIGNALS     = 2'd0,
        CFG_BASELINE_OFFSET = 2'd1,
        CFG_INVERSE_GAIN    = 2'd2,
        CFG_WINDOW_LENGTH   = 2'd3
    } cfg_reg_t;

    // Byte position inside a three-byte group
    localparam logic [1:0] PH_LOW  = 2'd0;
    localparam logic [1:0] PH_MID  = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;

    localparam int SAMPLE_W = 12;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int GAIN_W   = 24;
    localparam int PHYS_W   = 37;
    localparam int POS_W    = 16;
    localparam int WIN_W    = 20;
    localparam int CFG_W    = 24;

    // Decoded channel-0 sample with its window tags
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] raw;
        logic signed [DIFF_W-1:0]   diff;
        logic [POS_W-1:0]           position;
        logic                       last;
        logic [WIN_W-1:0]           number;
    } sample_t;

endpackage

// ===== src/packed_12bit_sample_windower.sv =====
`timescale 1ns / 1ps
// Channel | Signals                    | Payload
// --------+----------------------------+----------------------------------------
// cfg     | cfg_valid / cfg_ready      | cfg_index, cfg_data
// in      | in_valid / in_ready        | data_byte, record_start
// out     | out_valid / out_ready      | raw_sample, physical_value,
//         |                            | window_position, window_last, window_number
//
// One byte per cycle while in_ready is high. A channel-0 sample reaches the output
// through the unpack/counter register, then the multiply register.
// Reset clears byte phase and all counters; registers return to their defaults.
// A stalled output holds both stages; in_ready drops only when both are full.
// cfg_ready is always high.

module packed_12bit_sample_windower #(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_WINDOW   = 65535
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  pkwin_pkg::cfg_reg_t                   cfg_index,
    input  logic [pkwin_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [7:0]                            data_byte,
    input  logic                                  record_start,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [pkwin_pkg::SAMPLE_W-1:0] raw_sample,
    output logic signed [pkwin_pkg::PHYS_W-1:0]   physical_value,
    output logic [pkwin_pkg::POS_W-1:0]           window_position,
    output logic                                  window_last,
    output logic [pkwin_pkg::WIN_W-1:0]           window_number
);
    import pkwin_pkg::*;

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = ($clog2(MAX_CHANNELS + 1) > 5) ? $clog2(MAX_CHANNELS + 1) : 5;
    localparam int WL_W  = ($clog2(MAX_WINDOW + 1) > POS_W) ? $clog2(MAX_WINDOW + 1) : POS_W;
    localparam logic [CNT_W-1:0] MAX_CH_V = CNT_W'(MAX_CHANNELS);
    localparam logic [WL_W-1:0]  MAX_WL_V = WL_W'(MAX_WINDOW);

    logic [4:0]                 num_signals_reg;
    logic signed [SAMPLE_W-1:0] baseline_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic [POS_W-1:0]           window_length_reg;

    logic [CNT_W-1:0] num_ext;
    logic [CNT_W-1:0] chans;
    logic [WL_W-1:0]  len_ext;
    logic [WL_W-1:0]  len_clip;
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] len_m1;

    logic    s1_valid;
    logic    s1_ready;
    sample_t s1_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_signals_reg   <= 5'd2;
            baseline_reg      <= '0;
            gain_reg          <= GAIN_W'(65536);
            window_length_reg <= POS_W'(256);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_NUM_SIGNALS:     num_signals_reg   <= cfg_data[4:0];
                CFG_BASELINE_OFFSET: baseline_reg      <= cfg_data[SAMPLE_W-1:0];
                CFG_INVERSE_GAIN:    gain_reg          <= cfg_data[GAIN_W-1:0];
                CFG_WINDOW_LENGTH:   window_length_reg <= cfg_data[POS_W-1:0];
            endcase
        end
    end

    // clamp channel count and window length into their legal ranges
    always_comb
    begin
        num_ext = CNT_W'(num_signals_reg);
        if (num_ext == '0)
        begin
            chans = CNT_W'(1);
        end
        else if (num_ext > MAX_CH_V)
        begin
            chans = MAX_CH_V;
        end
        else
        begin
            chans = num_ext;
        end

        len_ext = WL_W'(window_length_reg);
        if (len_ext == '0)
        begin
            len_clip = WL_W'(1);
        end
        else if (len_ext > MAX_WL_V)
        begin
            len_clip = MAX_WL_V;
        end
        else
        begin
            len_clip = len_ext;
        end
        len    = len_clip[POS_W-1:0];
        len_m1 = len - POS_W'(1);
    end

    pkwin_unpack #(
        .CH_W  (CH_W),
        .CNT_W (CNT_W)
    ) u_unpack (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .record_start (record_start),
        .chans        (chans),
        .len          (len),
        .baseline     (baseline_reg),
        .s1_valid     (s1_valid),
        .s1_ready     (s1_ready),
        .s1_data      (s1_data)
    );

    pkwin_scale u_scale (
        .clk             (clk),
        .rst_n           (rst_n),
        .s1_valid        (s1_valid),
        .s1_ready        (s1_ready),
        .s1_data         (s1_data),
        .gain            (gain_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .raw_sample      (raw_sample),
        .physical_value  (physical_value),
        .window_position (window_position),
        .window_last     (window_last),
        .window_number   (window_number)
    );

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && window_last |-> window_position == len_m1)
        else $error("window_last away from window end");

    a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> window_position <= len_m1)
        else $error("window_position beyond window length");

    a_first_byte_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && record_start && !s1_valid |=> !s1_valid)
        else $error("result from the first byte of a record");

endmodule

// ===== src/pkwin_unpack.sv =====
`timescale 1ns / 1ps

module pkwin_unpack #(
    parameter int CH_W  = 4,
    parameter int CNT_W = 5
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [7:0]                            data_byte,
    input  logic                                  record_start,
    input  logic [CNT_W-1:0]                      chans,
    input  logic [pkwin_pkg::POS_W-1:0]           len,
    input  logic signed [pkwin_pkg::SAMPLE_W-1:0] baseline,
    output logic                                  s1_valid,
    input  logic                                  s1_ready,
    output pkwin_pkg::sample_t                    s1_data
);
    import pkwin_pkg::*;

    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;
    logic [7:0]       held_low_reg;
    logic [7:0]       held_mid_reg;
    logic [CH_W-1:0]  ch_reg;
    logic [POS_W-1:0] pos_reg;
    logic [WIN_W-1:0] win_reg;
    logic             s1_valid_reg;
    sample_t          s1_data_reg;

    logic [1:0]          phase;
    logic [CH_W-1:0]     ch_cur;
    logic [POS_W-1:0]    pos_cur;
    logic [WIN_W-1:0]    win_cur;
    logic                is_sample;
    logic signed [SAMPLE_W-1:0] raw;
    logic                ch0;
    logic [POS_W-1:0]    len_m1;
    logic [POS_W-1:0]    pos_clip;
    logic                last;
    logic [CNT_W-1:0]    ch_inc;
    logic [CH_W-1:0]     ch_wrap;
    logic                in_fire;
    logic                emit;

    assign in_ready = !s1_valid_reg || s1_ready;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        // record start clears the counters before this byte is taken
        phase   = record_start ? PH_LOW : phase_reg;
        ch_cur  = record_start ? '0 : ch_reg;
        pos_cur = record_start ? '0 : pos_reg;
        win_cur = record_start ? '0 : win_reg;

        is_sample  = 1'b0;
        raw        = '0;
        phase_next = PH_MID;
        unique case (phase)
            PH_MID:
            begin
                raw        = {data_byte[3:0], held_low_reg};
                is_sample  = 1'b1;
                phase_next = PH_HIGH;
            end
            PH_HIGH:
            begin
                raw        = {data_byte, held_mid_reg[7:4]};
                is_sample  = 1'b1;
                phase_next = PH_LOW;
            end
            default:
            begin
                phase_next = PH_MID;
            end
        endcase

        ch0      = (ch_cur == '0);
        len_m1   = len - POS_W'(1);
        pos_clip = (pos_cur >= len) ? len_m1 : pos_cur;
        last     = (pos_clip == len_m1);
        ch_inc   = CNT_W'(ch_cur) + CNT_W'(1);
        ch_wrap  = (ch_inc >= chans) ? '0 : ch_inc[CH_W-1:0];
        emit     = is_sample && ch0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LOW;
            held_low_reg <= '0;
            held_mid_reg <= '0;
            ch_reg       <= '0;
            pos_reg      <= '0;
            win_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_fire && emit;
            end
            if (in_fire)
            begin
                phase_reg <= phase_next;
                if (phase == PH_MID)
                begin
                    held_mid_reg <= data_byte;
                end
                else if (phase != PH_HIGH)
                begin
                    held_low_reg <= data_byte;
                end
                ch_reg <= is_sample ? ch_wrap : ch_cur;
                if (emit)
                begin
                    pos_reg <= last ? '0 : pos_clip + POS_W'(1);
                    win_reg <= last ? win_cur + WIN_W'(1) : win_cur;
                end
                else
                begin
                    pos_reg <= pos_cur;
                    win_reg <= win_cur;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg.raw      <= raw;
            s1_data_reg.diff     <= {raw[SAMPLE_W-1], raw} - {baseline[SAMPLE_W-1], baseline};
            s1_data_reg.position <= pos_clip;
            s1_data_reg.last     <= last;
            s1_data_reg.number   <= win_cur;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_data  = s1_data_reg;

endmodule

// ===== src/pkwin_scale.sv =====
`timescale 1ns / 1ps

module pkwin_scale (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s1_valid,
    output logic                                  s1_ready,
    input  pkwin_pkg::sample_t                    s1_data,
    input  logic [pkwin_pkg::GAIN_W-1:0]          gain,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [pkwin_pkg::SAMPLE_W-1:0] raw_sample,
    output logic signed [pkwin_pkg::PHYS_W-1:0]   physical_value,
    output logic [pkwin_pkg::POS_W-1:0]           window_position,
    output logic                                  window_last,
    output logic [pkwin_pkg::WIN_W-1:0]           window_number
);
    import pkwin_pkg::*;

    localparam int PROD_W = DIFF_W + GAIN_W + 1;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] raw_reg;
    logic signed [PHYS_W-1:0]   phys_reg;
    logic [POS_W-1:0]           pos_reg;
    logic                       last_reg;
    logic [WIN_W-1:0]           num_reg;
    logic signed [PROD_W-1:0]   prod;
    logic                       load;

    assign load     = !out_valid_reg || out_ready;
    assign s1_ready = load;

    // 13-bit signed times 24-bit unsigned; product fits in 37 bits
    assign prod = s1_data.diff * $signed({1'b0, gain});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && s1_valid)
        begin
            raw_reg  <= s1_data.raw;
            phys_reg <= prod[PHYS_W-1:0];
            pos_reg  <= s1_data.position;
            last_reg <= s1_data.last;
            num_reg  <= s1_data.number;
        end
    end

    assign out_valid       = out_valid_reg;
    assign raw_sample      = raw_reg;
    assign physical_value  = phys_reg;
    assign window_position = pos_reg;
    assign window_last     = last_reg;
    assign window_number   = num_reg;

endmodule

// ===== tb/pkwin_sample_checker.sv =====
`timescale 1ns / 1ps

module pkwin_sample_checker #(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_WINDOW   = 65535
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  pkwin_pkg::cfg_reg_t                   cfg_index,
    input  logic [pkwin_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic [7:0]                            data_byte,
    input  logic                                  record_start,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic signed [pkwin_pkg::SAMPLE_W-1:0] raw_sample,
    input  logic signed [pkwin_pkg::PHYS_W-1:0]   physical_value,
    input  logic [pkwin_pkg::POS_W-1:0]           window_position,
    input  logic                                  window_last,
    input  logic [pkwin_pkg::WIN_W-1:0]           window_number,
    output int                                    n_errors,
    output int                                    n_pending,
    output int                                    n_checked,
    output int                                    n_windows
);
    import pkwin_pkg::*;

    typedef struct {
        logic [SAMPLE_W-1:0] raw;
        logic [PHYS_W-1:0]   phys;
        logic [POS_W-1:0]    pos;
        logic                last;
        logic [WIN_W-1:0]    num;
    } window_sample_t;

    window_sample_t due_samples[$];
    window_sample_t head;

    // Register shadows
    logic [4:0]          num_signals_q;
    logic signed [11:0]  baseline_q;
    logic [23:0]         inv_gain_q;
    logic [15:0]         win_len_q;

    // Unpacker and counter shadows
    logic [1:0] phase;
    logic [7:0] held_low;
    logic [7:0] held_mid;
    int         chan_idx;
    int         pos_idx;
    int         win_idx;

    int errors  = 0;
    int checked = 0;
    int windows = 0;

    task automatic absorb_byte(input logic [7:0] b, input logic rs);
        logic [SAMPLE_W-1:0] word;
        logic                complete;
        int                  chans;
        int                  len;
        longint              prod;
        window_sample_t      s;
        complete = 1'b0;
        word     = '0;
        if (rs) begin
            phase    = PH_LOW;
            chan_idx = 0;
            pos_idx  = 0;
            win_idx  = 0;
        end
        if (phase == PH_MID) begin
            held_mid = b;
            word     = {b[3:0], held_low};
            complete = 1'b1;
            phase    = PH_HIGH;
        end else if (phase == PH_HIGH) begin
            word     = {b, held_mid[7:4]};
            complete = 1'b1;
            phase    = PH_LOW;
        end else begin
            // phase 3 is unreachable; it would behave as the low byte
            held_low = b;
            phase    = PH_MID;
        end
        if (complete) begin
            chans = (num_signals_q == 0) ? 1 :
                    (num_signals_q > MAX_CHANNELS) ? MAX_CHANNELS : int'(num_signals_q);
            len   = (win_len_q == 0) ? 1 :
                    (win_len_q > MAX_WINDOW) ? MAX_WINDOW : int'(win_len_q);
            if (chan_idx == 0) begin
                prod = (longint'($signed(word)) - longint'(baseline_q)) * longint'(inv_gain_q);
                // window may have shrunk under a running position
                if (pos_idx >= len)
                    pos_idx = len - 1;
                s.raw  = word;
                s.phys = prod[PHYS_W-1:0];
                s.pos  = pos_idx[POS_W-1:0];
                s.last = (pos_idx == len - 1);
                s.num  = win_idx[WIN_W-1:0];
                if (s.last) begin
                    pos_idx = 0;
                    win_idx = (win_idx + 1) & 'hFFFFF;
                end else begin
                    pos_idx++;
                end
                due_samples.insert(due_samples.size(), s);
            end
            chan_idx++;
            if (chan_idx >= chans)
                chan_idx = 0;
        end
    endtask

    function automatic bit field_ok(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            num_signals_q = 5'd2;
            baseline_q    = '0;
            inv_gain_q    = 24'd65536;
            win_len_q     = 16'd256;
            phase         = PH_LOW;
            held_low      = '0;
            held_mid      = '0;
            chan_idx      = 0;
            pos_idx       = 0;
            win_idx       = 0;
            due_samples.delete();
        end else begin
            // a byte taken at this edge still sees the old register values
            if (in_valid && in_ready)
                absorb_byte(data_byte, record_start);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_NUM_SIGNALS:     num_signals_q = cfg_data[4:0];
                    CFG_BASELINE_OFFSET: baseline_q    = cfg_data[11:0];
                    CFG_INVERSE_GAIN:    inv_gain_q    = cfg_data[23:0];
                    CFG_WINDOW_LENGTH:   win_len_q     = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (due_samples.size() == 0) begin
                    $display("%0t: unexpected sample, expected none, got raw %0h pos %0d",
                             $time, raw_sample, window_position);
                    errors++;
                end else begin
                    head = due_samples.pop_front();
                    if (!field_ok("raw_sample", 64'(head.raw), 64'($unsigned(raw_sample))))
                        errors++;
                    if (!field_ok("physical_value", 64'(head.phys),
                                  64'($unsigned(physical_value))))
                        errors++;
                    if (!field_ok("window_position", 64'(head.pos), 64'(window_position)))
                        errors++;
                    if (!field_ok("window_last", 64'(head.last), 64'(window_last)))
                        errors++;
                    if (!field_ok("window_number", 64'(head.num), 64'(window_number)))
                        errors++;
                    checked++;
                    if (head.last)
                        windows++;
                end
            end
        end
        n_errors  <= errors;
        n_pending <= due_samples.size();
        n_checked <= checked;
        n_windows <= windows;
    end

endmodule

// ===== tb/tb_packed_12bit_sample_windower.sv =====
`timescale 1ns / 1ps

module tb_packed_12bit_sample_windower;

    import pkwin_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_PHASES = 18;
    localparam int PHASE_BYTES   = 107;
    localparam int SETTLE_CYCLES = 4;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    cfg_reg_t             cfg_index    = CFG_NUM_SIGNALS;
    logic [CFG_W-1:0]     cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic [7:0]           data_byte    = '0;
    logic                 record_start = 1'b0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic signed [SAMPLE_W-1:0] raw_sample;
    logic signed [PHYS_W-1:0]   physical_value;
    logic [POS_W-1:0]     window_position;
    logic                 window_last;
    logic [WIN_W-1:0]     window_number;

    int n_errors;
    int n_pending;
    int n_checked;
    int n_windows;

    int cycles        = 0;
    int bytes_sent    = 0;
    int settings_used = 1;

    // output-side stall control
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   seg_left  = 0;
    int   stall_pct = 0;

    logic [8:0] directed_bytes[$];

    always #1 clk = ~clk;

    packed_12bit_sample_windower u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .record_start    (record_start),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .raw_sample      (raw_sample),
        .physical_value  (physical_value),
        .window_position (window_position),
        .window_last     (window_last),
        .window_number   (window_number)
    );

    pkwin_sample_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .record_start    (record_start),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .raw_sample      (raw_sample),
        .physical_value  (physical_value),
        .window_position (window_position),
        .window_last     (window_last),
        .window_number   (window_number),
        .n_errors        (n_errors),
        .n_pending       (n_pending),
        .n_checked       (n_checked),
        .n_windows       (n_windows)
    );

    // Receiver: random stall segments, plus one long hold-off on request
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
            seg_left  <= 0;
            stall_pct <= 0;
        end else if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            out_ready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            if (seg_left == 0) begin
                seg_left  <= $urandom_range(5, 60);
                stall_pct <= ($urandom_range(0, 2) == 0) ? 0 :
                             ($urandom_range(0, 1) == 0) ? 30 : 85;
            end else begin
                seg_left <= seg_left - 1;
            end
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d samples outstanding",
                     cycles, n_pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic rs);
        in_valid     <= 1'b1;
        data_byte    <= b;
        record_start <= rs;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic play_directed();
        foreach (directed_bytes[i])
            push_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
        in_valid <= 1'b0;
        directed_bytes.delete();
    endtask

    // Writes all four registers in one back-to-back run of transfers
    task automatic write_regs(input logic [4:0] nsig, input logic [11:0] base,
                              input logic [23:0] gain, input logic [15:0] wlen,
                              input bit junk);
        logic [CFG_W-1:0] noise;
        noise = CFG_W'($urandom);
        if (!junk)
            noise = '0;
        cfg_valid <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            case (i)
                0: begin
                    cfg_index <= CFG_NUM_SIGNALS;
                    cfg_data  <= {noise[23:5], nsig};
                end
                1: begin
                    cfg_index <= CFG_BASELINE_OFFSET;
                    cfg_data  <= {noise[23:12], base};
                end
                2: begin
                    cfg_index <= CFG_INVERSE_GAIN;
                    cfg_data  <= gain;
                end
                default: begin
                    cfg_index <= CFG_WINDOW_LENGTH;
                    cfg_data  <= {noise[23:16], wlen};
                end
            endcase
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (n_pending != 0)
            @(posedge clk);
        // bytes that yield no sample may still be in the pipe
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_stream(input int count);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 16);
            for (int k = 0; k < burst && left > 0; k++) begin
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 149) == 0);
                left--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0 && left > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    initial begin
        logic [4:0]  nsig;
        logic [11:0] base;
        logic [23:0] gain;
        logic [15:0] wlen;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults: extreme samples, then a record restart in the middle of a group
        directed_bytes = {9'h1FF, 9'h0F7, 9'h07F, 9'h000, 9'h008, 9'h080,
                          9'h05A, 9'h13C, 9'h0A5, 9'h096};
        play_directed();
        wait_idle();

        // Single channel, most negative baseline, full-scale gain, two-sample windows
        write_regs(5'd1, 12'h800, 24'hFFFFFF, 16'd2, 1'b0);
        directed_bytes = {9'h0FF, 9'h0F7, 9'h07F, 9'h000, 9'h008, 9'h080};
        play_directed();
        wait_idle();

        // Zero channel count, zero gain, zero window length
        write_regs(5'd0, 12'h7FF, 24'd0, 16'd0, 1'b0);
        directed_bytes = {9'h100, 9'h000, 9'h000};
        play_directed();
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin nsig = 5'd1;  base = 12'h000; gain = 24'd65536;   wlen = 16'd200;   end
                // short window right after a long one: position clamps
                1: begin nsig = 5'd1;  base = 12'h7FF; gain = 24'd1;       wlen = 16'd5;     end
                2: begin nsig = 5'd16; base = 12'h800; gain = 24'hFFFFFF;  wlen = 16'd3;     end
                3: begin nsig = 5'd31; base = 12'hFFF; gain = 24'd0;       wlen = 16'd1;     end
                4: begin nsig = 5'd17; base = 12'h001; gain = 24'd65536;   wlen = 16'hFFFF;  end
                5: begin nsig = 5'd0;  base = 12'h7FF; gain = 24'hFFFFFF;  wlen = 16'd0;     end
                6: begin nsig = 5'd2;  base = 12'h800; gain = 24'd1;       wlen = 16'd7;     end
                default: begin
                    nsig = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) :
                                                         5'($urandom_range(1, 3));
                    base = 12'($urandom);
                    gain = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 3)) :
                                                         24'($urandom);
                    wlen = ($urandom_range(0, 5) == 0) ? 16'($urandom) :
                                                         16'($urandom_range(0, 24));
                end
            endcase
            write_regs(nsig, base, gain, wlen, p >= 7);
            if (p == 1)
                hold_req <= 1'b1;
            run_stream(PHASE_BYTES);
            wait_idle();
        end

        $display("Streamed %0d bytes under %0d register settings with bursty input and stalls",
                 bytes_sent, settings_used);
        $display("Checked %0d channel-0 samples, %0d of them closing a full window",
                 n_checked, n_windows);
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
src/pkwin_pkg.sv
src/pkwin_unpack.sv
src/pkwin_scale.sv
src/packed_12bit_sample_windower.sv
tb/pkwin_sample_checker.sv
tb/tb_packed_12bit_sample_windower.sv
